### design/leb_pkg.sv
// Shared constants and types for the line edit buffer.
package leb_pkg;

   localparam int LINE_SIZE   = 256;
   localparam int CNT_W       = $clog2(LINE_SIZE + 1);
   localparam int CHAR_W      = 8;
   localparam int POS_W       = 9;
   localparam int IDX_W       = 8;
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_COUNT = (LINE_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] KEY_LEFT      = 8'h83;
   localparam logic [CHAR_W-1:0] KEY_RIGHT     = 8'h84;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic              do_insert;
      logic              do_delete;
      logic [CNT_W-1:0]  cursor;
      logic [CNT_W-1:0]  length;
      logic [CHAR_W-1:0] key;
      logic [CNT_W-1:0]  read_idx;
   } cell_ctl_type;

endpackage

### design/leb_cell.sv
// One character cell of the line: shifts with its neighbors on insert and delete.
module leb_cell (
   input  logic                        clock,
   input  logic [leb_pkg::CNT_W-1:0]   cell_index,
   input  leb_pkg::cell_ctl_type       ctl,
   input  logic [leb_pkg::CHAR_W-1:0]  left_data,
   input  logic [leb_pkg::CHAR_W-1:0]  right_data,
   output logic [leb_pkg::CHAR_W-1:0]  data,
   output logic [leb_pkg::CHAR_W-1:0]  read_data
);

   logic [leb_pkg::CHAR_W-1:0] data_ff;
   logic [leb_pkg::CHAR_W-1:0] data_in;
   logic [leb_pkg::CNT_W-1:0]  next_index;

   assign next_index = cell_index + leb_pkg::CNT_W'(1);

   always_comb begin
      data_in = data_ff;
      if (ctl.do_insert) begin
         if (cell_index == ctl.cursor) begin
            data_in = ctl.key;
         end else if (cell_index > ctl.cursor && cell_index <= ctl.length) begin
            data_in = left_data;
         end
      end else if (ctl.do_delete) begin
         if (next_index >= ctl.cursor && next_index < ctl.length) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign read_data = (ctl.read_idx == cell_index) ? data_ff : '0;

endmodule

### design/leb_gather.sv
// Registered two-level OR tree that collects the addressed cell's character.
module leb_gather (
   input  logic                        clock,
   input  logic                        load,
   input  logic [leb_pkg::CHAR_W-1:0]  cell_read [leb_pkg::LINE_SIZE],
   output logic [leb_pkg::CHAR_W-1:0]  gathered
);

   logic [leb_pkg::CHAR_W-1:0] group_ff [leb_pkg::GROUP_COUNT];
   logic [leb_pkg::CHAR_W-1:0] group_in [leb_pkg::GROUP_COUNT];

   always_comb begin
      for (int g = 0; g < leb_pkg::GROUP_COUNT; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < leb_pkg::GROUP_SIZE; j++) begin
            if (g * leb_pkg::GROUP_SIZE + j < leb_pkg::LINE_SIZE) begin
               group_in[g] = group_in[g] | cell_read[g * leb_pkg::GROUP_SIZE + j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         group_ff <= group_in;
      end
   end

   always_comb begin
      gathered = '0;
      for (int g = 0; g < leb_pkg::GROUP_COUNT; g++) begin
         gathered = gathered | group_ff[g];
      end
   end

endmodule

### design/line_edit_buffer.sv
// Line edit buffer: top level with cursor and length control and the row of cells.
//
// Requests arrive on req_*: req_tuser selects a key (0) or a read (1); req_tdata carries
// the key byte and the read index. Every request yields exactly one response on rsp_*,
// carrying cursor, length, the dropped flag and the read character.
// The line is held in a row of character cells; an insert shifts the tail right and a
// backspace shifts it left, all cells moving in the same cycle.
// A key request is answered in the cycle after acceptance. A read request is answered
// once the addressed character is collected through a registered OR tree over groups
// of cells and loaded into the output register; no request is taken before that.
// Throughput: one key request per cycle while the receiver does not stall.
// Reset clears cursor and length to zero and drops any pending response; cell
// contents stay undefined, and reads at or beyond the length return zero.
// When the receiver stalls, the response is held in the output register and
// req_tready stays low until the output register can take the next result.
module line_edit_buffer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [leb_pkg::REQ_DATA_W-1:0]  req_tdata,  // key[7:0], read_index[15:8]
   input  logic                            req_tuser,  // op[0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [leb_pkg::RSP_DATA_W-1:0]  rsp_tdata   // cursor[8:0], length[17:9],
                                                       // dropped[18], read_data[26:19]
);

   typedef enum logic {
      ST_IDLE,
      ST_GATHER
   } state_type;

   state_type                        state_ff;
   logic                             rsp_valid_ff;
   logic [leb_pkg::RSP_DATA_W-1:0]   rsp_data_ff;
   logic [leb_pkg::CNT_W-1:0]        cursor_ff;
   logic [leb_pkg::CNT_W-1:0]        length_ff;
   logic                             read_ok_ff;

   logic [leb_pkg::CNT_W-1:0]        cursor_in;
   logic [leb_pkg::CNT_W-1:0]        length_in;
   logic                             dropped_in;
   logic                             read_ok_in;
   logic                             accept;
   logic                             out_free;
   logic                             is_key;
   logic                             full;
   logic [leb_pkg::CHAR_W-1:0]       key;
   logic [leb_pkg::IDX_W-1:0]        read_index;
   leb_pkg::cell_ctl_type            ctl;
   logic [leb_pkg::CHAR_W-1:0]       cell_data [leb_pkg::LINE_SIZE];
   logic [leb_pkg::CHAR_W-1:0]       cell_read [leb_pkg::LINE_SIZE];
   logic [leb_pkg::CHAR_W-1:0]       gathered;

   assign key        = req_tdata[leb_pkg::CHAR_W-1:0];
   assign read_index = req_tdata[leb_pkg::CHAR_W +: leb_pkg::IDX_W];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_key     = (req_tuser == leb_pkg::OP_KEY);
   assign full       = (length_ff >= leb_pkg::CNT_W'(leb_pkg::LINE_SIZE));
   assign read_ok_in = (leb_pkg::CNT_W'(read_index) < length_ff);

   always_comb begin
      cursor_in  = cursor_ff;
      length_in  = length_ff;
      dropped_in = 1'b0;
      ctl        = '0;
      ctl.cursor   = cursor_ff;
      ctl.length   = length_ff;
      ctl.key      = key;
      ctl.read_idx = leb_pkg::CNT_W'(read_index);
      if (accept && is_key) begin
         unique case (key)
            leb_pkg::KEY_BACKSPACE: begin
               if (cursor_ff != '0) begin
                  ctl.do_delete = 1'b1;
                  cursor_in     = cursor_ff - leb_pkg::CNT_W'(1);
                  length_in     = length_ff - leb_pkg::CNT_W'(1);
               end
            end
            leb_pkg::KEY_NEWLINE: begin
               cursor_in = '0;
            end
            leb_pkg::KEY_LEFT: begin
               if (cursor_ff != '0) begin
                  cursor_in = cursor_ff - leb_pkg::CNT_W'(1);
               end
            end
            leb_pkg::KEY_RIGHT: begin
               if (cursor_ff < length_ff) begin
                  cursor_in = cursor_ff + leb_pkg::CNT_W'(1);
               end
            end
            default: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  ctl.do_insert = 1'b1;
                  cursor_in     = cursor_ff + leb_pkg::CNT_W'(1);
                  length_in     = length_ff + leb_pkg::CNT_W'(1);
               end
            end
         endcase
      end
   end

   for (genvar i = 0; i < leb_pkg::LINE_SIZE; i++) begin : g_cell
      logic [leb_pkg::CHAR_W-1:0] left_data;
      logic [leb_pkg::CHAR_W-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == leb_pkg::LINE_SIZE - 1) begin : g_tail
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      leb_cell u_cell (
         .clock      (clock),
         .cell_index (leb_pkg::CNT_W'(i)),
         .ctl        (ctl),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .read_data  (cell_read[i])
      );
   end

   leb_gather u_gather (
      .clock     (clock),
      .load      (accept && !is_key),
      .cell_read (cell_read),
      .gathered  (gathered)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '0;
         length_ff    <= '0;
         read_ok_ff   <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         length_ff <= length_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && is_key) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {5'd0, leb_pkg::CHAR_W'(0), dropped_in,
                                   leb_pkg::POS_W'(length_in),
                                   leb_pkg::POS_W'(cursor_in)};
               end else begin
                  if (rsp_valid_ff && rsp_tready) begin
                     rsp_valid_ff <= 1'b0;
                  end
                  if (accept) begin
                     read_ok_ff <= read_ok_in;
                     state_ff   <= ST_GATHER;
                  end
               end
            end
            ST_GATHER: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {5'd0, (read_ok_ff ? gathered : leb_pkg::CHAR_W'(0)),
                                   1'b0, leb_pkg::POS_W'(length_ff),
                                   leb_pkg::POS_W'(cursor_ff)};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### design/leb_checker.sv
// Port-level assertions for the line edit buffer, bound to the top level.
module leb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [leb_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic [leb_pkg::POS_W-1:0]  rsp_cursor;
   logic [leb_pkg::POS_W-1:0]  rsp_length;
   logic                       rsp_dropped;
   logic [leb_pkg::CHAR_W-1:0] rsp_read_data;

   assign rsp_cursor    = rsp_tdata[8:0];
   assign rsp_length    = rsp_tdata[17:9];
   assign rsp_dropped   = rsp_tdata[18];
   assign rsp_read_data = rsp_tdata[26:19];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_cursor <= rsp_length)
      else $error("cursor beyond length");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_dropped |->
         rsp_length == leb_pkg::POS_W'(leb_pkg::LINE_SIZE) && rsp_read_data == '0)
      else $error("drop reported on a line that is not full");

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### test/line_edit_buffer_check.sv
// Checker for the line edit buffer: tracks the line, predicts each response and compares it.
module line_edit_buffer_check import leb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    outstanding,
   output int                    errors,
   output logic [POS_W-1:0]      line_len
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CHAR_W-1:0] read_data;
      logic              dropped;
      logic [POS_W-1:0]  length;
      logic [POS_W-1:0]  cursor;
   } line_status_type;

   logic [CHAR_W-1:0] chars [LINE_SIZE];
   int unsigned       cur;
   int unsigned       len;
   line_status_type   status_q [$];
   int                fail_count;

   initial begin
      outstanding = 0;
      errors      = 0;
      line_len    = '0;
      fail_count  = 0;
      cur         = 0;
      len         = 0;
   end

   function automatic line_status_type edit_line(logic op, logic [CHAR_W-1:0] key,
                                                 logic [IDX_W-1:0] idx);
      line_status_type s;
      int unsigned     i;
      s = '0;
      if (op == OP_READ) begin
         if (idx < len) s.read_data = chars[idx];
      end else begin
         case (key)
            KEY_BACKSPACE: begin
               if (cur > 0) begin
                  for (i = cur; i < len; i++) chars[i-1] = chars[i];
                  cur--;
                  len--;
               end
            end
            KEY_NEWLINE: cur = 0;
            KEY_LEFT: begin
               if (cur > 0) cur--;
            end
            KEY_RIGHT: begin
               if (cur < len) cur++;
            end
            default: begin
               if (len >= LINE_SIZE) begin
                  s.dropped = 1'b1;
               end else begin
                  for (i = len; i > cur; i--) chars[i] = chars[i-1];
                  chars[cur] = key;
                  cur++;
                  len++;
               end
            end
         endcase
      end
      s.cursor = POS_W'(cur);
      s.length = POS_W'(len);
      return s;
   endfunction

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         fail_count++;
         $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      line_status_type got;
      line_status_type want;
      if (reset) begin
         cur = 0;
         len = 0;
         status_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = line_status_type'(rsp_tdata[$bits(line_status_type)-1:0]);
            if (status_q.size() == 0) begin
               fail_count++;
               $display("%0t response expected none actual %h", $time, rsp_tdata);
            end else begin
               want = status_q.pop_front();
               compare_field("cursor", want.cursor, got.cursor);
               compare_field("length", want.length, got.length);
               compare_field("dropped", want.dropped, got.dropped);
               compare_field("read_data", want.read_data, got.read_data);
            end
         end
         if (req_tvalid && req_tready)
            status_q.push_back(edit_line(req_tuser, req_tdata[CHAR_W-1:0],
                                         req_tdata[CHAR_W +: IDX_W]));
      end
      outstanding <= status_q.size();
      errors      <= fail_count;
      line_len    <= POS_W'(len);
   end

endmodule

### test/line_edit_buffer_test.sv
// Testbench top for the line edit buffer: clock, reset, stimulus, stalls and verdict.
module line_edit_buffer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import leb_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum logic [1:0] {SEG_FILL, SEG_DRAIN, SEG_MIX} segment_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    outstanding;
   int                    errors;
   logic [POS_W-1:0]      line_len;
   int                    cycles;
   bit                    steady;

   line_edit_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   line_edit_buffer_check checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .errors      (errors),
      .line_len    (line_len)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("line_edit_buffer: mismatch");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int hold;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   task automatic send_request(logic op, logic [CHAR_W-1:0] key, logic [IDX_W-1:0] idx);
      int gap;
      req_tuser  <= op;
      req_tdata  <= {idx, key};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_key(logic [CHAR_W-1:0] key);
      send_request(OP_KEY, key, IDX_W'($urandom_range(0, 255)));
   endtask

   task automatic send_read(logic [IDX_W-1:0] idx);
      send_request(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_move();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) send_key(KEY_LEFT);
      else if (r < 8) send_key(KEY_RIGHT);
      else send_key(KEY_NEWLINE);
   endtask

   task automatic send_random_read();
      if (line_len > 0 && $urandom_range(0, 99) < 85)
         send_read(IDX_W'($urandom_range(0, line_len - 1)));
      else
         send_read(IDX_W'($urandom_range(0, 255)));
   endtask

   task automatic send_random_item(segment_kind_type kind);
      int r;
      r = $urandom_range(0, 99);
      case (kind)
         SEG_FILL: begin
            if (r < 85) send_key(CHAR_W'($urandom_range(0, 255)));
            else if (r < 93) send_random_read();
            else send_move();
         end
         SEG_DRAIN: begin
            if (r < 65) send_key(KEY_BACKSPACE);
            else if (r < 80) send_random_read();
            else send_move();
         end
         default: begin
            if (r < 40) send_key(CHAR_W'($urandom_range(0, 255)));
            else if (r < 55) send_key(KEY_BACKSPACE);
            else if (r < 70) send_move();
            else send_random_read();
         end
      endcase
   endtask

   initial begin
      segment_kind_type kind;
      int               items_left;
      int               seg_len;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_KEY;
      steady = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_key(KEY_BACKSPACE);
      send_key(KEY_LEFT);
      send_key(KEY_RIGHT);
      send_key(KEY_NEWLINE);
      send_read(8'h00);
      send_key(8'h00);
      send_key(8'hFF);
      send_key(8'h41);
      send_read(8'h00);
      send_read(8'h01);
      send_read(8'h02);
      send_read(8'h03);
      send_read(8'hFF);
      send_key(KEY_LEFT);
      send_key(KEY_LEFT);
      send_key(8'h5A);
      send_key(KEY_BACKSPACE);
      send_key(KEY_BACKSPACE);
      send_key(KEY_BACKSPACE);
      send_key(KEY_RIGHT);
      send_key(KEY_RIGHT);
      send_key(KEY_RIGHT);
      send_key(KEY_NEWLINE);
      send_key(8'h7F);
      send_request(OP_READ, 8'hFF, 8'h00);
      wait_for_responses();

      items_left = RANDOM_ITEMS;
      kind       = SEG_FILL;
      seg_len    = 330;
      while (items_left > 0) begin
         if (seg_len > items_left) seg_len = items_left;
         steady = ($urandom_range(0, 4) == 0);
         repeat (seg_len) send_random_item(kind);
         items_left -= seg_len;
         if ($urandom_range(0, 3) == 0) wait_for_responses();
         kind    = segment_kind_type'($urandom_range(0, 2));
         seg_len = $urandom_range(40, 200);
      end

      wait_for_responses();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("line_edit_buffer: match");
      end else begin
         $display("line_edit_buffer: mismatch");
      end
      $finish;
   end

endmodule
